// File: rtl/tma_pkg.sv
// Shared types and constants for the three-means accumulator.
package tma_pkg;

  localparam int DATA_W    = 32;
  localparam int CNT_W     = 8;
  localparam int SUM_W     = 40;
  localparam int LOG_SUM_W = 30;
  localparam int LOG_FRAC  = 16;
  localparam int EXP_W     = 5;
  localparam int LOG_RES_W = EXP_W + LOG_FRAC;
  localparam int CFG_IDX_W = 8;

  localparam logic [CNT_W-1:0] MAX_SAMPLES   = 8'd255;
  localparam logic [CNT_W-1:0] MIN_COUNT_RST = 8'd3;
  localparam logic [CNT_W-1:0] MAX_COUNT_RST = 8'd100;
  localparam logic [SUM_W-1:0] SUM_MAX       = {SUM_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] REG_MIN_COUNT = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_COUNT = 8'd1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_RANGE     = 2'd1;
  localparam logic [1:0] ST_UNDEFINED = 2'd2;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_status_t;

endpackage

// File: rtl/tma_if.sv
// Channel interfaces: sample input, result output, register write.
interface tma_in_if;
  logic                        valid;
  logic                        ready;
  logic [tma_pkg::DATA_W-1:0]  sample;
  logic                        last;
  modport source (output valid, sample, last, input ready);
  modport sink   (input valid, sample, last, output ready);
endinterface

interface tma_out_if;
  logic                        valid;
  logic                        ready;
  logic [tma_pkg::DATA_W-1:0]  arithmetic_mean;
  logic [tma_pkg::DATA_W-1:0]  geometric_mean;
  logic [tma_pkg::DATA_W-1:0]  harmonic_mean;
  logic [1:0]                  status;
  modport source (output valid, arithmetic_mean, geometric_mean, harmonic_mean, status,
                  input ready);
  modport sink   (input valid, arithmetic_mean, geometric_mean, harmonic_mean, status,
                  output ready);
endinterface

interface tma_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [tma_pkg::CFG_IDX_W-1:0] index;
  logic [tma_pkg::CNT_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/tma_div.sv
// Restoring divider, one quotient bit per cycle.
module tma_div #(
  parameter int DW = 40
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [DW-1:0]             dividend,
  input  logic [tma_pkg::SUM_W-1:0] divisor,
  output tma_pkg::unit_status_t     st,
  output logic [DW-1:0]             quotient
);
  localparam int CW = $clog2(DW);

  logic                      busy_r, busy_nxt, done_r, done_nxt;
  logic [CW-1:0]             cnt_r, cnt_nxt;
  logic [DW-1:0]             quo_r, quo_nxt;
  logic [tma_pkg::SUM_W-1:0] rem_r, rem_nxt, dsr_r, dsr_nxt;
  logic [tma_pkg::SUM_W:0]   rem_sh;
  logic                      ge;

  assign rem_sh = {rem_r, quo_r[DW-1]};
  assign ge     = rem_sh >= {1'b0, dsr_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(DW - 1);
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? tma_pkg::SUM_W'(rem_sh - {1'b0, dsr_r})
                   : rem_sh[tma_pkg::SUM_W-1:0];
      quo_nxt = {quo_r[DW-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign st.busy  = busy_r;
  assign st.done  = done_r;
  assign quotient = quo_r;
endmodule

// File: rtl/tma_log2.sv
// Iterative log2: normalize one bit per cycle, then one squaring per fraction bit.
module tma_log2 (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [tma_pkg::DATA_W-1:0]    value,
  output tma_pkg::unit_status_t         st,
  output logic [tma_pkg::LOG_RES_W-1:0] result
);
  localparam int FW = $clog2(tma_pkg::LOG_FRAC);

  typedef enum logic [2:0] {
    L_IDLE = 3'b001,
    L_NORM = 3'b010,
    L_SQ   = 3'b100
  } lstate_t;

  lstate_t                        state_r, state_nxt;
  logic                           done_r, done_nxt;
  logic [tma_pkg::DATA_W-1:0]     m_r, m_nxt;
  logic [tma_pkg::EXP_W-1:0]      e_r, e_nxt;
  logic [tma_pkg::LOG_FRAC-1:0]   frac_r, frac_nxt;
  logic [FW-1:0]                  cnt_r, cnt_nxt;
  logic [2*tma_pkg::DATA_W-1:0]   sq;
  logic [tma_pkg::DATA_W:0]       sq_hi;

  assign sq    = m_r * m_r;
  assign sq_hi = sq[2*tma_pkg::DATA_W-1:tma_pkg::DATA_W-1];

  always_comb begin
    state_nxt = state_r;
    done_nxt  = 1'b0;
    m_nxt     = m_r;
    e_nxt     = e_r;
    frac_nxt  = frac_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      L_IDLE: begin
        if (start) begin
          m_nxt     = value;
          e_nxt     = '1;
          frac_nxt  = '0;
          cnt_nxt   = '1;
          state_nxt = L_NORM;
        end
      end
      L_NORM: begin
        if (m_r[tma_pkg::DATA_W-1]) begin
          state_nxt = L_SQ;
        end else begin
          m_nxt = {m_r[tma_pkg::DATA_W-2:0], 1'b0};
          e_nxt = e_r - 1'b1;
        end
      end
      L_SQ: begin
        if (sq_hi[tma_pkg::DATA_W]) begin
          m_nxt         = sq_hi[tma_pkg::DATA_W:1];
          frac_nxt[cnt_r] = 1'b1;
        end else begin
          m_nxt = sq_hi[tma_pkg::DATA_W-1:0];
        end
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = L_IDLE;
          done_nxt  = 1'b1;
        end
      end
      default: state_nxt = L_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= L_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    m_r    <= m_nxt;
    e_r    <= e_nxt;
    frac_r <= frac_nxt;
    cnt_r  <= cnt_nxt;
  end

  assign st.busy = (state_r != L_IDLE);
  assign st.done = done_r;
  assign result  = {e_r, frac_r};
endmodule

// File: rtl/three_means_accumulator.sv
// Top level: three-means accumulator with sequencer, shared divider and log2 unit.
//
// Usage:
//   in_ch   : valid/ready stream of samples (unsigned Q16.16) with a last flag.
//   out_ch  : one transaction per run, on the sample that carries last:
//             arithmetic, geometric and harmonic mean plus a status code
//             (0 ok, 1 count out of range, 2 harmonic mean undefined).
//   cfg_ch  : register writes, always ready; index 0 min_count, 1 max_count.
//             Write only while no run result is pending.
// Sequencing:
//   A nonzero sample runs the divider (reciprocal, DW = 2*FRACTION_BITS+8
//   quotient bits, at least 40) and the log2 unit side by side; a zero
//   sample skips both units.
//   The last sample of an in-range run adds up to three divider passes and,
//   if the run held no zero sample, 32 log2 passes for the geometric mean's
//   bit search. in_ch.ready is high only while the sequencer idles.
// Reset: registers return to 3 / 100, run state is cleared, no output pending.
// Stall: the result sits in an output register; the next run's samples are
//   still taken, and the block waits only when a new result would overwrite
//   one not yet taken.
module three_means_accumulator #(
  parameter int FRACTION_BITS = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  tma_in_if.sink         in_ch,
  tma_out_if.source      out_ch,
  tma_cfg_if.sink        cfg_ch
);
  localparam int DW = (2*FRACTION_BITS + 8 > 40) ? 2*FRACTION_BITS + 8 : 40;
  localparam int DATA_W = tma_pkg::DATA_W;
  localparam int CNT_W  = tma_pkg::CNT_W;
  localparam int SUM_W  = tma_pkg::SUM_W;
  localparam int LSW    = tma_pkg::LOG_SUM_W;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_SAMP = 9'b000000010,
    S_ACC  = 9'b000000100,
    S_EVAL = 9'b000001000,
    S_AM   = 9'b000010000,
    S_HM   = 9'b000100000,
    S_LM   = 9'b001000000,
    S_EXP  = 9'b010000000,
    S_DONE = 9'b100000000
  } state_t;

  state_t                 state_r, state_nxt;
  logic [DATA_W-1:0]      sample_r, sample_nxt;
  logic                   last_r, last_nxt;
  logic [CNT_W-1:0]       count_r, count_nxt, min_r, max_r;
  logic [SUM_W-1:0]       vsum_r, vsum_nxt, rsum_r, rsum_nxt;
  logic [LSW-1:0]         lsum_r, lsum_nxt, mlog_r, mlog_nxt;
  logic                   zero_r, zero_nxt, ovf_r, ovf_nxt;
  logic [DATA_W-1:0]      am_r, am_nxt, gm_r, gm_nxt, hm_r, hm_nxt, exp_r, exp_nxt;
  logic [1:0]             st_r, st_nxt;
  logic [4:0]             bit_r, bit_nxt;
  logic                   ov_r;
  logic [DATA_W-1:0]      oam_r, ogm_r, ohm_r;
  logic [1:0]             ost_r;
  logic                   out_load;

  logic                   div_start, log_start;
  logic [DW-1:0]          div_dividend, div_q;
  logic [SUM_W-1:0]       div_divisor;
  logic [DATA_W-1:0]      log_value, cand, r_upd;
  logic [tma_pkg::LOG_RES_W-1:0] log_res;
  tma_pkg::unit_status_t  div_st, log_st;

  logic                   accept, skip;
  logic [DW:0]            rsum_add;
  logic [DATA_W-1:0]      q_sat;

  tma_div #(.DW(DW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_dividend),
    .divisor(div_divisor), .st(div_st), .quotient(div_q)
  );

  tma_log2 u_log (
    .clk(clk), .rst_n(rst_n), .start(log_start), .value(log_value),
    .st(log_st), .result(log_res)
  );

  assign accept   = in_ch.valid && in_ch.ready;
  assign skip     = (count_r >= tma_pkg::MAX_SAMPLES) || (in_ch.sample == '0);
  assign rsum_add = (DW+1)'(rsum_r) + (DW+1)'(div_q);
  assign q_sat    = (|div_q[DW-1:DATA_W]) ? '1 : div_q[DATA_W-1:0];
  assign cand     = exp_r | (DATA_W'(1) << bit_r);
  assign r_upd    = ((LSW)'(log_res) <= mlog_r) ? cand : exp_r;

  always_comb begin
    state_nxt    = state_r;
    sample_nxt   = sample_r;
    last_nxt     = last_r;
    count_nxt    = count_r;
    vsum_nxt     = vsum_r;
    rsum_nxt     = rsum_r;
    lsum_nxt     = lsum_r;
    zero_nxt     = zero_r;
    ovf_nxt      = ovf_r;
    mlog_nxt     = mlog_r;
    am_nxt       = am_r;
    gm_nxt       = gm_r;
    hm_nxt       = hm_r;
    st_nxt       = st_r;
    exp_nxt      = exp_r;
    bit_nxt      = bit_r;
    out_load     = 1'b0;
    div_start    = 1'b0;
    log_start    = 1'b0;
    div_dividend = DW'(1) << (2*FRACTION_BITS);
    div_divisor  = SUM_W'(in_ch.sample);
    log_value    = in_ch.sample;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          sample_nxt = in_ch.sample;
          last_nxt   = in_ch.last;
          if (skip) begin
            state_nxt = S_ACC;
          end else begin
            div_start = 1'b1;
            log_start = 1'b1;
            state_nxt = S_SAMP;
          end
        end
      end
      S_SAMP: begin
        if (!div_st.busy && !log_st.busy) state_nxt = S_ACC;
      end
      S_ACC: begin
        if (count_r >= tma_pkg::MAX_SAMPLES) begin
          ovf_nxt = 1'b1;
        end else begin
          count_nxt = count_r + 1'b1;
          vsum_nxt  = vsum_r + SUM_W'(sample_r);
          if (sample_r == '0) begin
            zero_nxt = 1'b1;
          end else begin
            rsum_nxt = (rsum_add > (DW+1)'(tma_pkg::SUM_MAX)) ? tma_pkg::SUM_MAX
                                                              : rsum_add[SUM_W-1:0];
            lsum_nxt = lsum_r + LSW'(log_res);
          end
        end
        state_nxt = last_r ? S_EVAL : S_IDLE;
      end
      S_EVAL: begin
        am_nxt = '0;
        gm_nxt = '0;
        hm_nxt = '0;
        if (ovf_r || count_r == '0 || count_r < min_r || count_r > max_r) begin
          st_nxt    = tma_pkg::ST_RANGE;
          state_nxt = S_DONE;
        end else begin
          st_nxt       = (rsum_r == '0) ? tma_pkg::ST_UNDEFINED : tma_pkg::ST_OK;
          div_start    = 1'b1;
          div_dividend = DW'(vsum_r);
          div_divisor  = SUM_W'(count_r);
          state_nxt    = S_AM;
        end
      end
      S_AM: begin
        if (div_st.done) begin
          am_nxt = q_sat;
          if (rsum_r != '0) begin
            div_start    = 1'b1;
            div_dividend = DW'(count_r) << (2*FRACTION_BITS);
            div_divisor  = rsum_r;
            state_nxt    = S_HM;
          end else if (!zero_r) begin
            div_start    = 1'b1;
            div_dividend = DW'(lsum_r);
            div_divisor  = SUM_W'(count_r);
            state_nxt    = S_LM;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_HM: begin
        if (div_st.done) begin
          hm_nxt = q_sat;
          if (!zero_r) begin
            div_start    = 1'b1;
            div_dividend = DW'(lsum_r);
            div_divisor  = SUM_W'(count_r);
            state_nxt    = S_LM;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_LM: begin
        if (div_st.done) begin
          mlog_nxt  = div_q[LSW-1:0];
          exp_nxt   = '0;
          bit_nxt   = '1;
          log_start = 1'b1;
          log_value = DATA_W'(1) << (DATA_W - 1);
          state_nxt = S_EXP;
        end
      end
      S_EXP: begin
        // bit search: keep each candidate bit whose log2 stays within the mean
        if (log_st.done) begin
          exp_nxt = r_upd;
          if (bit_r == '0) begin
            gm_nxt    = r_upd;
            state_nxt = S_DONE;
          end else begin
            bit_nxt   = bit_r - 1'b1;
            log_start = 1'b1;
            log_value = r_upd | (DATA_W'(1) << (bit_r - 1'b1));
          end
        end
      end
      S_DONE: begin
        if (!ov_r || out_ch.ready) begin
          out_load  = 1'b1;
          count_nxt = '0;
          vsum_nxt  = '0;
          rsum_nxt  = '0;
          lsum_nxt  = '0;
          zero_nxt  = 1'b0;
          ovf_nxt   = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      vsum_r  <= '0;
      rsum_r  <= '0;
      lsum_r  <= '0;
      zero_r  <= 1'b0;
      ovf_r   <= 1'b0;
      min_r   <= tma_pkg::MIN_COUNT_RST;
      max_r   <= tma_pkg::MAX_COUNT_RST;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      vsum_r  <= vsum_nxt;
      rsum_r  <= rsum_nxt;
      lsum_r  <= lsum_nxt;
      zero_r  <= zero_nxt;
      ovf_r   <= ovf_nxt;
      if (cfg_ch.valid && cfg_ch.index == tma_pkg::REG_MIN_COUNT) min_r <= cfg_ch.data;
      if (cfg_ch.valid && cfg_ch.index == tma_pkg::REG_MAX_COUNT) max_r <= cfg_ch.data;
      if (out_load)          ov_r <= 1'b1;
      else if (out_ch.ready) ov_r <= 1'b0;
    end
    sample_r <= sample_nxt;
    last_r   <= last_nxt;
    mlog_r   <= mlog_nxt;
    am_r     <= am_nxt;
    gm_r     <= gm_nxt;
    hm_r     <= hm_nxt;
    st_r     <= st_nxt;
    exp_r    <= exp_nxt;
    bit_r    <= bit_nxt;
    if (out_load) begin
      oam_r <= am_r;
      ogm_r <= gm_r;
      ohm_r <= hm_r;
      ost_r <= st_r;
    end
  end

  assign in_ch.ready            = (state_r == S_IDLE);
  assign cfg_ch.ready           = 1'b1;
  assign out_ch.valid           = ov_r;
  assign out_ch.arithmetic_mean = oam_r;
  assign out_ch.geometric_mean  = ogm_r;
  assign out_ch.harmonic_mean   = ohm_r;
  assign out_ch.status          = ost_r;

`ifndef SYNTHESIS
  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_st.busy) else $error("divider restarted while busy");
  a_log_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    log_start |-> !log_st.busy) else $error("log2 unit restarted while busy");
  a_units_launch: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !skip) |=> (div_st.busy && log_st.busy))
    else $error("sample units not launched");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!ov_r || out_ch.ready)) else $error("pending result overwritten");
`endif
endmodule

// File: dv/three_means_accumulator_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for three_means_accumulator: random runs, scoreboard, config phases.
module three_means_accumulator_test;

  typedef struct {
    logic [tma_pkg::DATA_W-1:0] arith;
    logic [tma_pkg::DATA_W-1:0] geo;
    logic [tma_pkg::DATA_W-1:0] harm;
    logic [1:0]                 status;
  } mean_set_t;

  // Scoreboard: mirrors the run accumulators and keeps a queue of expected means.
  class means_scoreboard;
    logic [tma_pkg::CNT_W-1:0]     min_cnt;
    logic [tma_pkg::CNT_W-1:0]     max_cnt;
    logic [tma_pkg::CNT_W-1:0]     count;
    logic [tma_pkg::SUM_W-1:0]     value_acc;
    logic [tma_pkg::SUM_W-1:0]     recip_acc;
    logic [tma_pkg::LOG_SUM_W-1:0] log_acc;
    bit                            saw_zero;
    bit                            too_many;
    mean_set_t                     pending_means[$];
    int                            errors;

    function void clear_run();
      count = 0;
      value_acc = 0;
      recip_acc = 0;
      log_acc = 0;
      saw_zero = 0;
      too_many = 0;
    endfunction

    function void reset_state();
      min_cnt = tma_pkg::MIN_COUNT_RST;
      max_cnt = tma_pkg::MAX_COUNT_RST;
      errors = 0;
      clear_run();
    endfunction

    function void write_reg(logic [tma_pkg::CFG_IDX_W-1:0] idx,
                            logic [tma_pkg::CNT_W-1:0] val);
      if (idx == tma_pkg::REG_MIN_COUNT) min_cnt = val;
      else if (idx == tma_pkg::REG_MAX_COUNT) max_cnt = val;
    endfunction

    // log2 of a raw value, 16 fraction bits, by repeated squaring
    function logic [31:0] log2_q16(logic [31:0] r);
      logic [63:0] m;
      logic [31:0] res;
      int e;
      e = 0;
      if (r == 0) return 0;
      while (e < 31 && (r >> (e + 1)) != 0) e++;
      m = 64'(r) << (31 - e);
      res = e << tma_pkg::LOG_FRAC;
      for (int b = tma_pkg::LOG_FRAC - 1; b >= 0; b--) begin
        m = (m * m) >> 31;
        if (m >= 64'h1_0000_0000) begin
          m = m >> 1;
          res[b] = 1'b1;
        end
      end
      return res;
    endfunction

    // largest raw value whose log2 does not exceed the target
    function logic [31:0] exp2_q16(logic [31:0] target);
      logic [31:0] r;
      logic [31:0] c;
      r = 0;
      for (int b = 31; b >= 0; b--) begin
        c = r | (32'd1 << b);
        if (log2_q16(c) <= target) r = c;
      end
      return r;
    endfunction

    function void note_sample(logic [tma_pkg::DATA_W-1:0] s, logic last);
      logic [63:0] t;
      logic [31:0] lsum;
      mean_set_t   m;
      if (count >= tma_pkg::MAX_SAMPLES) begin
        too_many = 1;
      end else begin
        count++;
        value_acc = value_acc + s;
        if (s == 0) begin
          saw_zero = 1;
        end else begin
          t = 64'(recip_acc) + (64'h1_0000_0000 / s);
          recip_acc = (t > 64'(tma_pkg::SUM_MAX)) ? tma_pkg::SUM_MAX
                                                   : t[tma_pkg::SUM_W-1:0];
          lsum = 32'(log_acc) + log2_q16(s);
          log_acc = lsum[tma_pkg::LOG_SUM_W-1:0];
        end
      end
      if (!last) return;
      m = '{arith: 0, geo: 0, harm: 0, status: tma_pkg::ST_OK};
      if (too_many || count == 0 || count < min_cnt || count > max_cnt) begin
        m.status = tma_pkg::ST_RANGE;
      end else begin
        t = 64'(value_acc) / count;
        m.arith = (t > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : t[31:0];
        if (!saw_zero) m.geo = exp2_q16(32'(log_acc) / count);
        if (recip_acc == 0) begin
          m.status = tma_pkg::ST_UNDEFINED;
        end else begin
          t = (64'(count) << 32) / recip_acc;
          m.harm = (t > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : t[31:0];
        end
      end
      pending_means.push_back(m);
      clear_run();
    endfunction

    function void check_result(mean_set_t got);
      mean_set_t want;
      if (pending_means.size() == 0) begin
        $display("%0t: unexpected result am=%h gm=%h hm=%h st=%0d", $time,
                 got.arith, got.geo, got.harm, got.status);
        errors++;
        return;
      end
      want = pending_means.pop_front();
      if (got.arith !== want.arith) begin
        $display("%0t: arithmetic_mean expected %h actual %h", $time, want.arith, got.arith);
        errors++;
      end
      if (got.geo !== want.geo) begin
        $display("%0t: geometric_mean expected %h actual %h", $time, want.geo, got.geo);
        errors++;
      end
      if (got.harm !== want.harm) begin
        $display("%0t: harmonic_mean expected %h actual %h", $time, want.harm, got.harm);
        errors++;
      end
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        errors++;
      end
    endfunction
  endclass

  // A last sample takes longest, with its extra divider and log2 passes; allow a long margin for stalls on top.
  localparam int STALL_LIMIT = 20000;
  localparam int RANDOM_ITEMS = 1350;

  logic clk;
  logic rst_n;
  bit   quiet;          // no idling on either side once set
  int   sent_random;
  int   stall_cycles;
  means_scoreboard sb;

  tma_in_if  in_ch();
  tma_out_if out_ch();
  tma_cfg_if cfg_ch();

  three_means_accumulator uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  always #5 clk = ~clk;

  // Watchdog: any transaction on any channel restarts the count.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("three_means_accumulator_test: errors");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Result side: check every accepted transaction against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result('{arith: out_ch.arithmetic_mean, geo: out_ch.geometric_mean,
                         harm: out_ch.harmonic_mean, status: out_ch.status});
  end

  // Receiver backpressure: random bursts of low ready, none once quiet.
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
      end else if (!quiet && $urandom_range(5) == 0) begin
        out_ch.ready <= 1'b0;
        hold = $urandom_range(17, 1) - 1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Drive one sample; returns after the edge where it was accepted.
  task automatic send_sample(logic [tma_pkg::DATA_W-1:0] s, logic last);
    @(negedge clk);
    if (!quiet && $urandom_range(7) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(17, 1)) @(negedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.sample <= s;
    in_ch.last   <= last;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_sample(s, last);
  endtask

  task automatic release_input();
    @(negedge clk);
    in_ch.valid <= 1'b0;
  endtask

  // Hold off until every result has come back, then let the block settle.
  task automatic drain();
    release_input();
    while (sb.pending_means.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  // Register write; only called after drain(), so the block is idle.
  task automatic write_cfg(logic [tma_pkg::CFG_IDX_W-1:0] idx,
                           logic [tma_pkg::CNT_W-1:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [tma_pkg::DATA_W-1:0] pick_sample();
    case ($urandom_range(9))
      0:       return '0;
      1:       return $urandom_range(255, 1);
      2:       return $urandom_range(32'hFFFF_FFFF, 32'hFFFF_0000);
      3:       return $urandom_range(32'h0002_0000, 32'h0000_8000);  // around 1.0
      default: return $urandom;
    endcase
  endfunction

  // One run of n samples, the last one flagged.
  task automatic send_run(int n);
    for (int i = 0; i < n; i++) begin
      send_sample(pick_sample(), i == n - 1);
      sent_random++;
    end
  endtask

  // Mostly runs inside [min,max]; about one in ten is off-range noise.
  task automatic random_runs(int items);
    int lo;
    int hi;
    int n;
    int stop_at;
    stop_at = sent_random + items;
    while (sent_random < stop_at) begin
      lo = sb.min_cnt;
      hi = sb.max_cnt;
      if (lo > hi) n = $urandom_range(12, 1);
      else if ($urandom_range(9) == 0)
        n = (lo > 1 && $urandom_range(1)) ? $urandom_range(lo - 1, 1)
                                          : $urandom_range(hi + 3 > 258 ? 258 : hi + 3, hi + 1);
      else n = $urandom_range(hi > lo + 10 ? lo + 10 : hi, lo);
      if (sent_random > RANDOM_ITEMS * 85 / 100) quiet = 1;
      send_run(n);
    end
  endtask

  initial begin
    sb = new();
    sb.reset_state();
    clk = 0;
    rst_n = 0;
    quiet = 0;
    sent_random = 0;
    stall_cycles = 0;
    in_ch.valid = 0;
    in_ch.sample = '0;
    in_ch.last = 0;
    out_ch.ready = 0;
    cfg_ch.valid = 0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed runs under the reset limits (3..100).
    send_sample(32'hFFFF_FFFF, 0);    // largest sample
    send_sample(32'h0000_0001, 0);    // smallest nonzero: biggest reciprocal
    send_sample(32'h0001_0000, 1);    // exactly 1.0
    send_sample(32'h0004_0000, 0);
    send_sample(32'h0000_0000, 0);    // zero forces geometric mean to 0
    send_sample(32'h0010_0000, 1);
    send_sample(32'h0, 0);            // all zero: harmonic undefined
    send_sample(32'h0, 0);
    send_sample(32'h0, 1);
    send_sample(32'h0001_0000, 1);    // single-sample run, below min_count
    send_sample(32'h0003_0000, 0);
    send_sample(32'h0003_0000, 1);    // two samples, still short
    send_sample(32'h8000_0000, 0);
    send_sample(32'h7FFF_FFFF, 0);
    send_sample(32'h5555_5555, 0);
    send_sample(32'hAAAA_AAAA, 1);
    drain();

    random_runs(300);
    drain();                          // sender waits for every result here

    write_cfg(tma_pkg::REG_MIN_COUNT, 8'd1);
    write_cfg(tma_pkg::REG_MAX_COUNT, 8'd255);
    random_runs(250);
    drain();

    // Full-size runs: exactly MAX_SAMPLES, then past it (overflow).
    write_cfg(tma_pkg::REG_MIN_COUNT, 8'd255);
    send_run(255);
    send_run(258);
    drain();

    write_cfg(tma_pkg::REG_MIN_COUNT, 8'd1);
    write_cfg(tma_pkg::REG_MAX_COUNT, 8'd1);
    random_runs(120);
    drain();

    write_cfg(tma_pkg::REG_MIN_COUNT, 8'd10);  // min above max: every run is out of range
    write_cfg(tma_pkg::REG_MAX_COUNT, 8'd5);
    random_runs(80);
    drain();

    write_cfg(8'd2, 8'd77);           // unknown index, ignored
    write_cfg(tma_pkg::REG_MIN_COUNT, 8'd2);
    write_cfg(tma_pkg::REG_MAX_COUNT, 8'd20);
    random_runs(RANDOM_ITEMS - sent_random);
    drain();

    if (sb.errors == 0 && sb.pending_means.size() == 0) begin
      $display("three_means_accumulator_test: clean");
    end else begin
      if (sb.pending_means.size() != 0)
        $display("%0t: %0d results never arrived", $time, sb.pending_means.size());
      $display("three_means_accumulator_test: errors");
    end
    $finish;
  end

endmodule
